### rtl/ac253_pkg.sv
package ac253_pkg;

  localparam int ByteW = 8;
  localparam int ItemN = 7;
  localparam int AccW  = 48;
  localparam int OutW  = 128;

  localparam logic [2:0] ITEM_SRC   = 3'd0;
  localparam logic [2:0] ITEM_TYPE  = 3'd1;
  localparam logic [2:0] ITEM_APP   = 3'd2;
  localparam logic [2:0] ITEM_SVC   = 3'd3;
  localparam logic [2:0] ITEM_STATE = 3'd4;
  localparam logic [2:0] ITEM_ADP   = 3'd5;
  localparam logic [2:0] ITEM_FREQ  = 3'd6;

  localparam logic [1:0] KIND_UNKNOWN = 2'd0;
  localparam logic [1:0] KIND_CHANNEL = 2'd1;
  localparam logic [1:0] KIND_RADIO   = 2'd2;
  localparam logic [1:0] KIND_BEARING = 2'd3;

  localparam logic [7:0] CODE_CHANNEL = 8'd9;
  localparam logic [7:0] CODE_RADIO   = 8'd10;
  localparam logic [7:0] CODE_BEARING = 8'd22;

  localparam int ERR_EXT     = 0;
  localparam int ERR_END     = 1;
  localparam int ERR_NO_SRC  = 2;
  localparam int ERR_NO_TYPE = 3;

  typedef struct packed {
    logic [3:0]  error_flags;
    logic [6:0]  items_present;
    logic [15:0] bearing_raw;
    logic [31:0] frequency_value;
    logic [7:0]  adapter_second;
    logic [7:0]  adapter_first;
    logic [1:0]  message_kind;
    logic [7:0]  state_code;
    logic [15:0] application_code;
    logic [7:0]  service_code;
    logic [7:0]  source_id;
    logic [7:0]  source_area;
  } rec_t;

  typedef struct packed {
    logic       done;
    logic [2:0] idx;
    logic [3:0] err;
  } next_t;

  function automatic logic [2:0] item_len(input logic [2:0] idx);
    logic [2:0] len;
    case (idx)
      ITEM_SRC:   len = 3'd2;
      ITEM_TYPE:  len = 3'd1;
      ITEM_APP:   len = 3'd2;
      ITEM_SVC:   len = 3'd1;
      ITEM_STATE: len = 3'd1;
      ITEM_ADP:   len = 3'd2;
      default:    len = 3'd6;
    endcase
    return len;
  endfunction

  function automatic logic [1:0] map_kind(input logic [7:0] code);
    logic [1:0] k;
    case (code)
      CODE_CHANNEL: k = KIND_CHANNEL;
      CODE_RADIO:   k = KIND_RADIO;
      CODE_BEARING: k = KIND_BEARING;
      default:      k = KIND_UNKNOWN;
    endcase
    return k;
  endfunction

  // first present item at or after start; absent mandatory items flag errors
  function automatic next_t next_item(input logic [7:0] mask, input logic [1:0] kind,
                                      input logic [3:0] start);
    next_t res;
    logic  found;
    logic  pres;
    res   = '{done: 1'b1, idx: 3'd0, err: 4'd0};
    found = 1'b0;
    for (int k = 0; k < ItemN; k++) begin
      if (!found && (k >= int'(start))) begin
        pres = mask[7-k];
        if (k == int'(ITEM_FREQ)) pres = pres && (kind == KIND_BEARING);
        if (pres) begin
          found    = 1'b1;
          res.done = 1'b0;
          res.idx  = 3'(k);
        end else begin
          if (k == int'(ITEM_SRC))  res.err[ERR_NO_SRC]  = 1'b1;
          if (k == int'(ITEM_TYPE)) res.err[ERR_NO_TYPE] = 1'b1;
        end
      end
    end
    return res;
  endfunction

endpackage

### rtl/ac253_parser.sv
module ac253_parser (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      step,
  input  logic [ac253_pkg::ByteW-1:0] data_byte,
  input  logic                      last,
  output ac253_pkg::rec_t           rec
);
  import ac253_pkg::*;

  typedef enum logic [3:0] {
    ST_MASK = 4'b0001,
    ST_EXT  = 4'b0010,
    ST_ITEM = 4'b0100,
    ST_DONE = 4'b1000
  } stage_t;

  stage_t          stage_r, stage_nxt;
  logic [2:0]      idx_r, idx_nxt;
  logic [2:0]      cnt_r, cnt_nxt;
  logic [7:0]      mask_r, mask_nxt;
  logic [AccW-1:0] acc_r, acc_nxt;
  logic [6:0]      cap_r, cap_nxt;
  logic [3:0]      err_r, err_nxt;
  logic [1:0]      kind_r, kind_nxt;
  logic [7:0]      area_r, area_nxt, sid_r, sid_nxt, svc_r, svc_nxt;
  logic [15:0]     app_r, app_nxt, brg_r, brg_nxt;
  logic [7:0]      st_r, st_nxt, adp1_r, adp1_nxt, adp2_r, adp2_nxt;
  logic [31:0]     freq_r, freq_nxt;

  logic            seek;
  logic [7:0]      seek_mask;
  logic [3:0]      seek_start;
  next_t           ni;

  always_comb begin
    stage_nxt  = stage_r;
    idx_nxt    = idx_r;
    cnt_nxt    = cnt_r;
    mask_nxt   = mask_r;
    acc_nxt    = acc_r;
    cap_nxt    = cap_r;
    err_nxt    = err_r;
    kind_nxt   = kind_r;
    area_nxt   = area_r;
    sid_nxt    = sid_r;
    svc_nxt    = svc_r;
    app_nxt    = app_r;
    st_nxt     = st_r;
    adp1_nxt   = adp1_r;
    adp2_nxt   = adp2_r;
    freq_nxt   = freq_r;
    brg_nxt    = brg_r;
    seek       = 1'b0;
    seek_mask  = mask_r;
    seek_start = 4'd0;
    unique case (stage_r)
      ST_MASK: begin
        mask_nxt  = data_byte;
        seek_mask = data_byte;
        if (data_byte[0]) stage_nxt = ST_EXT;
        else              seek      = 1'b1;
      end
      ST_EXT: begin
        if (!data_byte[0]) begin
          err_nxt[ERR_EXT] = 1'b1;
          stage_nxt        = ST_DONE;
        end
      end
      ST_ITEM: begin
        acc_nxt = {acc_r[AccW-9:0], data_byte};
        cnt_nxt = cnt_r + 3'd1;
        if (cnt_nxt == item_len(idx_r)) begin
          case (idx_r)
            ITEM_SRC: begin
              area_nxt = acc_nxt[15:8];
              sid_nxt  = acc_nxt[7:0];
            end
            ITEM_TYPE:  kind_nxt = map_kind(acc_nxt[7:0]);
            ITEM_APP:   app_nxt  = acc_nxt[15:0];
            ITEM_SVC:   svc_nxt  = acc_nxt[7:0];
            ITEM_STATE: st_nxt   = acc_nxt[7:0];
            ITEM_ADP: begin
              adp1_nxt = acc_nxt[15:8];
              adp2_nxt = acc_nxt[7:0];
            end
            default: begin
              freq_nxt = acc_nxt[47:16];
              brg_nxt  = acc_nxt[15:0];
            end
          endcase
          cap_nxt[idx_r] = 1'b1;
          seek           = 1'b1;
          seek_start     = {1'b0, idx_r} + 4'd1;
        end
      end
      ST_DONE: ;
      default: stage_nxt = ST_MASK;
    endcase
    ni = next_item(seek_mask, kind_nxt, seek_start);
    if (seek) begin
      err_nxt = err_nxt | ni.err;
      cnt_nxt = 3'd0;
      idx_nxt = ni.idx;
      stage_nxt = ni.done ? ST_DONE : ST_ITEM;
    end
  end

  always_comb begin
    rec.source_area      = cap_nxt[ITEM_SRC]   ? area_nxt : 8'd0;
    rec.source_id        = cap_nxt[ITEM_SRC]   ? sid_nxt  : 8'd0;
    rec.service_code     = cap_nxt[ITEM_SVC]   ? svc_nxt  : 8'd0;
    rec.application_code = cap_nxt[ITEM_APP]   ? app_nxt  : 16'd0;
    rec.state_code       = cap_nxt[ITEM_STATE] ? st_nxt   : 8'd0;
    rec.message_kind     = cap_nxt[ITEM_TYPE]  ? kind_nxt : KIND_UNKNOWN;
    rec.adapter_first    = cap_nxt[ITEM_ADP]   ? adp1_nxt : 8'd0;
    rec.adapter_second   = cap_nxt[ITEM_ADP]   ? adp2_nxt : 8'd0;
    rec.frequency_value  = cap_nxt[ITEM_FREQ]  ? freq_nxt : 32'd0;
    rec.bearing_raw      = cap_nxt[ITEM_FREQ]  ? brg_nxt  : 16'd0;
    rec.items_present    = cap_nxt;
    rec.error_flags      = err_nxt;
    if (stage_nxt != ST_DONE) rec.error_flags[ERR_END] = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r <= ST_MASK;
      idx_r   <= 3'd0;
      cnt_r   <= 3'd0;
      mask_r  <= 8'd0;
      cap_r   <= 7'd0;
      err_r   <= 4'd0;
      kind_r  <= KIND_UNKNOWN;
    end else if (step) begin
      if (last) begin
        stage_r <= ST_MASK;
        idx_r   <= 3'd0;
        cnt_r   <= 3'd0;
        mask_r  <= 8'd0;
        cap_r   <= 7'd0;
        err_r   <= 4'd0;
        kind_r  <= KIND_UNKNOWN;
      end else begin
        stage_r <= stage_nxt;
        idx_r   <= idx_nxt;
        cnt_r   <= cnt_nxt;
        mask_r  <= mask_nxt;
        cap_r   <= cap_nxt;
        err_r   <= err_nxt;
        kind_r  <= kind_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      acc_r  <= acc_nxt;
      area_r <= area_nxt;
      sid_r  <= sid_nxt;
      svc_r  <= svc_nxt;
      app_r  <= app_nxt;
      st_r   <= st_nxt;
      adp1_r <= adp1_nxt;
      adp2_r <= adp2_nxt;
      freq_r <= freq_nxt;
      brg_r  <= brg_nxt;
    end
  end

endmodule

### rtl/asterix_cat253_record_parser.sv
// Category-253 record decoder.
// in_*: one record byte per request, in_tlast on the record's last byte.
//   The first byte is the presence mask; items follow in mask order.
// out_*: one result request per record, issued for the byte with in_tlast;
//   bytes without in_tlast produce nothing.
// Throughput: one byte per cycle; a last byte waits while the result
//   register is held. Each byte only steps the parse state in ac253_parser,
//   which sits between the input stage register and the result register.
// Stall: the result register holds while out_tready is low; input keeps
//   flowing until the next last byte reaches the input stage register,
//   which then holds that byte, and in_tready drops.
// Reset (rst_n low, synchronous): parser returns to awaiting a presence
//   mask, both stage registers are emptied.
module asterix_cat253_record_parser (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [ac253_pkg::ByteW-1:0] in_tdata,  // [7:0] data_byte
  input  logic                        in_tlast,  // end_of_record
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // [7:0] source_area, [15:8] source_id, [23:16] service_code,
  // [39:24] application_code, [47:40] state_code, [49:48] message_kind,
  // [57:50] adapter_first, [65:58] adapter_second, [97:66] frequency_value,
  // [113:98] bearing_raw, [120:114] items_present, [124:121] error_flags
  output logic [ac253_pkg::OutW-1:0]  out_tdata
);
  import ac253_pkg::*;

  logic             stg_vld_r;
  logic [ByteW-1:0] stg_byte_r;
  logic             stg_last_r;
  logic             out_vld_r;
  rec_t             out_rec_r;
  rec_t             rec;
  logic             out_free;
  logic             stg_go;
  logic             in_acc;

  assign out_free  = !out_vld_r || out_tready;
  assign stg_go    = stg_vld_r && (!stg_last_r || out_free);
  assign in_tready = !stg_vld_r || stg_go;
  assign in_acc    = in_tvalid && in_tready;

  ac253_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (stg_go),
    .data_byte (stg_byte_r),
    .last      (stg_last_r),
    .rec       (rec)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_vld_r <= 1'b0;
    end else if (in_acc) begin
      stg_vld_r <= 1'b1;
    end else if (stg_go) begin
      stg_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      stg_byte_r <= in_tdata;
      stg_last_r <= in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (stg_go && stg_last_r) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stg_go && stg_last_r) out_rec_r <= rec;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{(OutW - $bits(rec_t)){1'b0}}, out_rec_r};

  a_ext_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_rec_r.error_flags[ERR_EXT] |->
      !out_rec_r.error_flags[ERR_NO_SRC] && !out_rec_r.error_flags[ERR_NO_TYPE]
      && (out_rec_r.items_present == 7'd0))
    else $error("extended mask result carries item data or item errors");

  a_freq_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_rec_r.items_present[ITEM_FREQ] |->
      out_rec_r.items_present[ITEM_TYPE] && (out_rec_r.message_kind == KIND_BEARING))
    else $error("frequency/bearing captured without bearing message kind");

  a_kind_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && (out_rec_r.message_kind != KIND_UNKNOWN) |->
      out_rec_r.items_present[ITEM_TYPE])
    else $error("message kind set without a captured type item");

  a_res_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_vld_r) |-> $past(stg_vld_r && stg_last_r))
    else $error("result raised without a last byte in the parse stage");

endmodule

### bench/asterix_cat253_record_parser_test.sv
module asterix_cat253_record_parser_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ac253_pkg::*;

  typedef enum logic [1:0] {PH_MASK, PH_EXT, PH_ITEM, PH_DONE} parse_phase_t;

  typedef struct {
    logic [7:0] data;
    logic       eor;
    bit         drain;
  } link_byte_t;

  localparam int ITEM_BYTES [ItemN] = '{2, 1, 2, 1, 1, 2, 6};

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [ByteW-1:0]  in_tdata = '0;
  logic              in_tlast = 1'b0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [OutW-1:0]   out_tdata;

  asterix_cat253_record_parser uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  link_byte_t   pending_bytes[$];
  rec_t         expected_records[$];
  int           fail_count = 0;

  // decoder state
  parse_phase_t phase = PH_MASK;
  logic [2:0]   cur_item = '0;
  logic [2:0]   byte_cnt = '0;
  logic [7:0]   mask_r = '0;
  logic [47:0]  acc = '0;
  rec_t         fld = '0;  // fields stay zero until their item is captured

  function automatic void clear_parse();
    phase    = PH_MASK;
    cur_item = '0;
    byte_cnt = '0;
    mask_r   = '0;
    acc      = '0;
    fld      = '0;
  endfunction

  function automatic void seek_item(input int start);
    int k;
    bit found;
    bit pres;
    found = 1'b0;
    for (k = start; k < ItemN; k++) begin
      if (!found) begin
        pres = mask_r[7-k];
        if (k == int'(ITEM_FREQ)) pres = pres && (fld.message_kind == KIND_BEARING);
        if (pres) begin
          found    = 1'b1;
          phase    = PH_ITEM;
          cur_item = 3'(k);
          byte_cnt = '0;
          acc      = '0;
        end else begin
          if (k == int'(ITEM_SRC))  fld.error_flags[ERR_NO_SRC]  = 1'b1;
          if (k == int'(ITEM_TYPE)) fld.error_flags[ERR_NO_TYPE] = 1'b1;
        end
      end
    end
    if (!found) phase = PH_DONE;
  endfunction

  function automatic void store_item();
    case (cur_item)
      ITEM_SRC: begin
        fld.source_area = acc[15:8];
        fld.source_id   = acc[7:0];
      end
      ITEM_TYPE: begin
        case (acc[7:0])
          CODE_CHANNEL: fld.message_kind = KIND_CHANNEL;
          CODE_RADIO:   fld.message_kind = KIND_RADIO;
          CODE_BEARING: fld.message_kind = KIND_BEARING;
          default:      fld.message_kind = KIND_UNKNOWN;
        endcase
      end
      ITEM_APP:   fld.application_code = acc[15:0];
      ITEM_SVC:   fld.service_code = acc[7:0];
      ITEM_STATE: fld.state_code = acc[7:0];
      ITEM_ADP: begin
        fld.adapter_first  = acc[15:8];
        fld.adapter_second = acc[7:0];
      end
      default: begin
        fld.frequency_value = acc[47:16];
        fld.bearing_raw     = acc[15:0];
      end
    endcase
    fld.items_present[cur_item] = 1'b1;
  endfunction

  task automatic decode_byte(input logic [7:0] b, input logic eor);
    case (phase)
      PH_MASK: begin
        mask_r = b;
        if (b[0]) phase = PH_EXT;
        else seek_item(0);
      end
      PH_EXT: begin
        if (!b[0]) begin
          fld.error_flags[ERR_EXT] = 1'b1;
          phase = PH_DONE;
        end
      end
      PH_ITEM: begin
        acc      = {acc[39:0], b};
        byte_cnt = byte_cnt + 3'd1;
        if (int'(byte_cnt) >= ITEM_BYTES[cur_item]) begin
          store_item();
          seek_item(int'(cur_item) + 1);
        end
      end
      default: ;
    endcase
    if (eor) begin
      if (phase != PH_DONE) fld.error_flags[ERR_END] = 1'b1;
      expected_records.push_back(fld);
      clear_parse();
    end
  endtask

  task automatic report(input string msg);
    if (fail_count < 40) $display("%0t ns: %s", $time, msg);
    fail_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report($sformatf("%s: got %0h, expected %0h", name, got, want));
  endtask

  task automatic compare_record(input rec_t got, input rec_t want);
    check_field("source_area", 32'(got.source_area), 32'(want.source_area));
    check_field("source_id", 32'(got.source_id), 32'(want.source_id));
    check_field("service_code", 32'(got.service_code), 32'(want.service_code));
    check_field("application_code", 32'(got.application_code),
                32'(want.application_code));
    check_field("state_code", 32'(got.state_code), 32'(want.state_code));
    check_field("message_kind", 32'(got.message_kind), 32'(want.message_kind));
    check_field("adapter_first", 32'(got.adapter_first), 32'(want.adapter_first));
    check_field("adapter_second", 32'(got.adapter_second), 32'(want.adapter_second));
    check_field("frequency_value", got.frequency_value, want.frequency_value);
    check_field("bearing_raw", 32'(got.bearing_raw), 32'(want.bearing_raw));
    check_field("items_present", 32'(got.items_present), 32'(want.items_present));
    check_field("error_flags", 32'(got.error_flags), 32'(want.error_flags));
  endtask

  bit calm_tx = 1'b0;
  bit calm_rx = 1'b0;

  function automatic int draw_wait(input bit calm);
    return calm ? 0 : $urandom_range(0, 7);
  endfunction

  // sender
  int         send_wait = 0;
  logic       nxt_valid;
  link_byte_t cur;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      in_tlast  <= 1'b0;
      send_wait = 0;
    end else begin
      nxt_valid = in_tvalid;
      if (in_tvalid && in_tready) begin
        decode_byte(in_tdata, in_tlast);
        nxt_valid = 1'b0;
        if ($urandom_range(0, 63) == 0) calm_tx = !calm_tx;
        send_wait = draw_wait(calm_tx);
      end
      if (!nxt_valid) begin
        if (send_wait > 0) begin
          send_wait--;
        end else if (pending_bytes.size() > 0 &&
                     !(pending_bytes[0].drain && expected_records.size() > 0)) begin
          cur = pending_bytes.pop_front();
          nxt_valid = 1'b1;
          in_tdata <= cur.data;
          in_tlast <= cur.eor;
        end
      end
      in_tvalid <= nxt_valid;
    end
  end

  // receiver
  int   ready_wait = 0;
  logic nxt_ready;
  rec_t got_rec;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      ready_wait = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got_rec = out_tdata[$bits(rec_t)-1:0];
        if (expected_records.size() == 0) report("result request with nothing expected");
        else compare_record(got_rec, expected_records.pop_front());
        if ($urandom_range(0, 63) == 0) calm_rx = !calm_rx;
        ready_wait = draw_wait(calm_rx);
      end
      if (ready_wait > 0) begin
        nxt_ready = 1'b0;
        ready_wait--;
      end else begin
        nxt_ready = 1'b1;
      end
      out_tready <= nxt_ready;
    end
  end

  task automatic put(input logic [7:0] d, input logic eor, input bit drain = 1'b0);
    pending_bytes.push_back('{data: d, eor: eor, drain: drain});
  endtask

  // one record, mostly well formed; sometimes cut short or padded
  task automatic gen_record(input bit drain, output int count);
    logic [7:0] body[$];
    logic [7:0] m;
    logic [7:0] code;
    int r;
    int n;
    int cut;
    int i;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      m = 8'($urandom_range(0, 255));
      m[0] = 1'b1;
      body.push_back(m);
      n = $urandom_range(0, 3);
      repeat (n) body.push_back(8'($urandom_range(0, 255)) | 8'h01);
      body.push_back(8'($urandom_range(0, 255)) & 8'hFE);
    end else begin
      m = 8'($urandom_range(0, 255));
      m[0] = 1'b0;
      if ($urandom_range(0, 9) < 8) m[7] = 1'b1;
      if ($urandom_range(0, 9) < 8) m[6] = 1'b1;
      body.push_back(m);
      case ($urandom_range(0, 4))
        0:       code = CODE_CHANNEL;
        1:       code = CODE_RADIO;
        2, 3:    code = CODE_BEARING;
        default: code = 8'($urandom_range(0, 255));
      endcase
      if (m[7]) repeat (2) body.push_back(8'($urandom_range(0, 255)));
      if (m[6]) body.push_back(code);
      if (m[5]) repeat (2) body.push_back(8'($urandom_range(0, 255)));
      if (m[4]) body.push_back(8'($urandom_range(0, 255)));
      if (m[3]) body.push_back(8'($urandom_range(0, 255)));
      if (m[2]) repeat (2) body.push_back(8'($urandom_range(0, 255)));
      if (m[1] && (code == CODE_BEARING || $urandom_range(0, 3) == 0))
        repeat (6) body.push_back(8'($urandom_range(0, 255)));
    end
    r = $urandom_range(0, 99);
    if (r < 12 && body.size() > 1) begin
      cut = $urandom_range(1, body.size() - 1);
      while (body.size() > cut) void'(body.pop_back());
    end else if (r < 24) begin
      n = $urandom_range(1, 3);
      repeat (n) body.push_back(8'($urandom_range(0, 255)));
    end
    for (i = 0; i < body.size(); i++)
      put(body[i], i == body.size() - 1, drain && i == 0);
    count = body.size();
  endtask

  int rand_bytes;
  int rec_count;
  int got_count;
  int i;

  initial begin
    // empty mask: both mandatory items missing
    put(8'h00, 1'b1);
    // every item, bearing kind, all-ones content
    put(8'hFE, 1'b0);
    put(8'hFF, 1'b0);
    put(8'hFF, 1'b0);
    put(CODE_BEARING, 1'b0);
    for (i = 0; i < 12; i++) put(8'hFF, i == 11);
    // frequency flagged but kind is radio; trailing byte ignored
    put(8'h42, 1'b0);
    put(CODE_RADIO, 1'b0);
    put(8'h00, 1'b1);
    // extension octets
    put(8'h01, 1'b0);
    put(8'hFF, 1'b0);
    put(8'h00, 1'b1);
    // end of data inside an item, then inside the extension
    put(8'h80, 1'b0);
    put(8'h12, 1'b1);
    put(8'h03, 1'b1);

    rand_bytes = 0;
    rec_count  = 0;
    while (rand_bytes < 900) begin
      gen_record(rec_count % 40 == 0, got_count);
      rand_bytes += got_count;
      rec_count++;
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_bytes.size() > 0 || in_tvalid || expected_records.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);

    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

### filelist.f
rtl/ac253_pkg.sv
rtl/ac253_parser.sv
rtl/asterix_cat253_record_parser.sv
bench/asterix_cat253_record_parser_test.sv
